// ----- hw/rtl/cpet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpet_pkg
// Shared types and constants for the calendar period energy totals block.
// ----------------------------------------------------------------------------
package cpet_pkg;

	localparam int unsigned EnergyW = 32;
	localparam int unsigned SecsW   = 32;
	localparam int unsigned TotalW  = 32;

	// Period number widths (unsigned, reset to all ones)
	localparam int unsigned DayNumW   = 17;
	localparam int unsigned WeekNumW  = 14;
	localparam int unsigned MonthNumW = 16;
	localparam int unsigned YearNumW  = 13;

	// Day count since the epoch fits 16 bits for the whole 32-bit second range
	localparam int unsigned DaysW = 16;

	// secs / 86400 = (secs >> 7) / 675; reciprocal of 675 scaled by 2^35
	localparam int unsigned SecShift   = 7;
	localparam logic [25:0] Recip675   = 26'd50903317;
	localparam int unsigned Recip675Sh = 35;

	// (days + 3) / 7; reciprocal of 7 scaled by 2^19
	localparam logic [15:0] WeekShift  = 16'd3;
	localparam logic [16:0] Recip7     = 17'd74899;
	localparam int unsigned Recip7Sh   = 19;

	// Civil conversion: day offset to 0000-03-01 and era bases
	localparam logic [19:0] CivilOffset = 20'd719468;
	localparam logic [19:0] Era5Base    = 20'd730485;
	localparam logic [19:0] Era4Base    = 20'd584388;
	localparam logic [17:0] DaysPer4Cen = 18'd146096;
	localparam logic [17:0] DaysPerCen  = 18'd36524;

	// Reciprocal of 365 scaled by 2^24, reciprocal of 100 by 2^16, of 153 by 2^18
	localparam logic [15:0] Recip365   = 16'd45965;
	localparam int unsigned Recip365Sh = 24;
	localparam logic [9:0]  Recip100   = 10'd656;
	localparam int unsigned Recip100Sh = 16;
	localparam logic [10:0] Recip153   = 11'd1714;
	localparam int unsigned Recip153Sh = 18;

	localparam logic [11:0] Era4Year = 12'd1600;
	localparam logic [11:0] Era5Year = 12'd2000;

	// Item carried alongside the date pipeline
	typedef struct packed {
		logic [EnergyW-1:0] energy;
		logic               ok;
	} cpet_tag_t;

	// Period numbers of one session
	typedef struct packed {
		logic [DayNumW-1:0]   day;
		logic [WeekNumW-1:0]  week;
		logic [MonthNumW-1:0] month;
		logic [YearNumW-1:0]  year;
	} cpet_period_t;

endpackage

// ----- hw/rtl/cpet_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpet_in_if
// Session channel: one finished session per transaction.
// ----------------------------------------------------------------------------
interface cpet_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] session_energy;
	logic [31:0] local_seconds;
	logic        clock_ok;

	modport source (output valid, session_energy, local_seconds, clock_ok, input ready);
	modport sink (input valid, session_energy, local_seconds, clock_ok, output ready);
endinterface

// ----- hw/rtl/cpet_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpet_out_if
// Totals channel: all running totals after one session per transaction.
// ----------------------------------------------------------------------------
interface cpet_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] lifetime_total;
	logic [31:0] day_total;
	logic [31:0] week_total;
	logic [31:0] month_total;
	logic [31:0] year_total;
	logic [31:0] session_count;

	modport source (output valid, lifetime_total, day_total, week_total, month_total,
		year_total, session_count, input ready);
	modport sink (input valid, lifetime_total, day_total, week_total, month_total,
		year_total, session_count, output ready);
endinterface

// ----- hw/rtl/cpet_civil.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpet_civil
// Eight-stage pipeline from local seconds to day, week, month and year
// numbers, using reciprocal multiplies and comparisons for the constant divisions.
// ----------------------------------------------------------------------------
module cpet_civil
	import cpet_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [SecsW-1:0]   secs,
	input  cpet_tag_t          tag,
	output logic               out_valid,
	output cpet_period_t       period,
	output cpet_tag_t          out_tag
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [SecsW-1:0] secs_s1;
	cpet_tag_t        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [DaysW-1:0] days_s2, days_s3, days_s4, days_s5, days_s6, days_s7;
	logic [WeekNumW-1:0] week_s3, week_s4, week_s5, week_s6, week_s7;
	logic             era5_s3, era5_s4, era5_s5, era5_s6, era5_s7;
	logic [17:0]      doe_s3, doe_s4, doe_s5;
	logic [17:0]      t_s4;
	logic [8:0]       yoe_s5, yoe_s6, yoe_s7;
	logic [8:0]       doy_s6;
	logic [3:0]       mp_s7;
	cpet_period_t     period_s8;

	// Stage 1 to 2: day count
	logic [50:0]      day_prod;
	logic [DaysW-1:0] days_c;

	// Stage 2 to 3: week, era and day of era
	logic [DaysW-1:0] wk_arg;
	logic [32:0]      wk_prod;
	logic [19:0]      z_c;
	logic             era5_c;
	logic [19:0]      doe_wide;

	// Stage 3 to 4: corrected day of era
	logic [31:0]      a_prod;
	logic [7:0]       a_c;
	logic [2:0]       b_c;
	logic             c_c;
	logic [17:0]      t_c;

	// Stage 4 to 5: year of era
	logic [33:0]      yoe_prod;

	// Stage 5 to 6: day of year
	logic [18:0]      c100_prod;
	logic [17:0]      year_base;
	logic [17:0]      doy_wide;

	// Stage 6 to 7: shifted month
	logic [10:0]      mp_num;
	logic [21:0]      mp_prod;

	// Stage 7 to 8: civil month and year
	logic [3:0]       mo_c;
	logic [11:0]      yr_c;
	logic [15:0]      mnum_c;

	always_comb begin
		day_prod = 51'(secs_s1[SecsW-1:SecShift]) * 51'(Recip675);
		days_c   = day_prod[Recip675Sh +: DaysW];
	end

	always_comb begin
		wk_arg   = days_s2 + WeekShift;
		wk_prod  = 33'(wk_arg) * 33'(Recip7);
		z_c      = 20'(days_s2) + CivilOffset;
		era5_c   = (z_c >= Era5Base);
		doe_wide = era5_c ? (z_c - Era5Base) : (z_c - Era4Base);
	end

	// Leap corrections: doe/1460, doe/36524 and doe/146096
	always_comb begin
		a_prod = 32'(doe_s3[17:2]) * 32'(Recip365);
		a_c    = a_prod[Recip365Sh +: 8];
		if (doe_s3 >= DaysPer4Cen) begin
			b_c = 3'd4;
		end else if (doe_s3 >= 18'(3 * 36524)) begin
			b_c = 3'd3;
		end else if (doe_s3 >= 18'(2 * 36524)) begin
			b_c = 3'd2;
		end else if (doe_s3 >= DaysPerCen) begin
			b_c = 3'd1;
		end else begin
			b_c = 3'd0;
		end
		c_c = (doe_s3 == DaysPer4Cen);
		t_c = doe_s3 - 18'(a_c) + 18'(b_c) - 18'(c_c);
	end

	always_comb begin
		yoe_prod = 34'(t_s4) * 34'(Recip365);
	end

	always_comb begin
		c100_prod = 19'(yoe_s5) * 19'(Recip100);
		year_base = 18'(yoe_s5) * 18'd365 + 18'(yoe_s5[8:2])
			- 18'(c100_prod[Recip100Sh +: 3]);
		doy_wide  = doe_s5 - year_base;
	end

	always_comb begin
		mp_num  = 11'(doy_s6) * 11'd5 + 11'd2;
		mp_prod = 22'(mp_num) * 22'(Recip153);
	end

	// Map March-based month back to January-based and finish the year
	always_comb begin
		mo_c   = (mp_s7 < 4'd10) ? (mp_s7 + 4'd3) : (mp_s7 - 4'd9);
		yr_c   = 12'(yoe_s7) + (era5_s7 ? Era5Year : Era4Year) + 12'(mo_c <= 4'd2);
		mnum_c = 16'(yr_c) * 16'd12 + 16'(mo_c) - 16'd1;
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= secs;
			tag_s1  <= tag;

			days_s2 <= days_c;
			tag_s2  <= tag_s1;

			days_s3 <= days_s2;
			week_s3 <= wk_prod[Recip7Sh +: WeekNumW];
			era5_s3 <= era5_c;
			doe_s3  <= doe_wide[17:0];
			tag_s3  <= tag_s2;

			t_s4    <= t_c;
			doe_s4  <= doe_s3;
			days_s4 <= days_s3;
			week_s4 <= week_s3;
			era5_s4 <= era5_s3;
			tag_s4  <= tag_s3;

			yoe_s5  <= yoe_prod[Recip365Sh +: 9];
			doe_s5  <= doe_s4;
			days_s5 <= days_s4;
			week_s5 <= week_s4;
			era5_s5 <= era5_s4;
			tag_s5  <= tag_s4;

			doy_s6  <= doy_wide[8:0];
			yoe_s6  <= yoe_s5;
			days_s6 <= days_s5;
			week_s6 <= week_s5;
			era5_s6 <= era5_s5;
			tag_s6  <= tag_s5;

			mp_s7   <= mp_prod[Recip153Sh +: 4];
			yoe_s7  <= yoe_s6;
			days_s7 <= days_s6;
			week_s7 <= week_s6;
			era5_s7 <= era5_s6;
			tag_s7  <= tag_s6;

			period_s8.day   <= DayNumW'(days_s7);
			period_s8.week  <= week_s7;
			period_s8.month <= mnum_c;
			period_s8.year  <= YearNumW'(yr_c);
			tag_s8          <= tag_s7;
		end
	end

	assign out_valid = v_s8;
	assign period    = period_s8;
	assign out_tag   = tag_s8;

endmodule

// ----- hw/rtl/calendar_period_energy_totals.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_period_energy_totals
// Path: a session transaction passes the eight date stages, then the totals register.
// Throughput: one session per cycle; the eight-stage date pipeline and the
// totals register stall together only while a result waits on the output.
// Reset: totals and session count clear to zero, period numbers to all ones.
// ----------------------------------------------------------------------------
module calendar_period_energy_totals
	import cpet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cpet_in_if.sink     session,
	cpet_out_if.source  totals
);

	logic         en;
	logic         civ_valid;
	cpet_period_t civ_period;
	cpet_tag_t    civ_tag;
	cpet_tag_t    in_tag;

	logic [TotalW-1:0] lifetime_q, day_q, week_q, month_q, year_q, count_q;
	logic [DayNumW-1:0]   day_num_q;
	logic [WeekNumW-1:0]  week_num_q;
	logic [MonthNumW-1:0] month_num_q;
	logic [YearNumW-1:0]  year_num_q;
	logic                 out_valid_q;

	logic [TotalW-1:0] day_base, week_base, month_base, year_base;

	// Whole pipeline moves unless a result is held on the output
	assign en            = !out_valid_q || totals.ready;
	assign session.ready = en;

	assign in_tag.energy = session.session_energy;
	assign in_tag.ok     = session.clock_ok;

	cpet_civil u_civil (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (session.valid),
		.secs      (session.local_seconds),
		.tag       (in_tag),
		.out_valid (civ_valid),
		.period    (civ_period),
		.out_tag   (civ_tag)
	);

	// Drop a period total when its number changes
	always_comb begin
		day_base   = (day_num_q   == civ_period.day)   ? day_q   : '0;
		week_base  = (week_num_q  == civ_period.week)  ? week_q  : '0;
		month_base = (month_num_q == civ_period.month) ? month_q : '0;
		year_base  = (year_num_q  == civ_period.year)  ? year_q  : '0;
	end

	// Update totals and flag a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q  <= '0;
			day_q       <= '0;
			week_q      <= '0;
			month_q     <= '0;
			year_q      <= '0;
			count_q     <= '0;
			day_num_q   <= '1;
			week_num_q  <= '1;
			month_num_q <= '1;
			year_num_q  <= '1;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= civ_valid;
			if (civ_valid) begin
				lifetime_q <= lifetime_q + civ_tag.energy;
				count_q    <= count_q + TotalW'(1);
				if (civ_tag.ok) begin
					day_q       <= day_base + civ_tag.energy;
					week_q      <= week_base + civ_tag.energy;
					month_q     <= month_base + civ_tag.energy;
					year_q      <= year_base + civ_tag.energy;
					day_num_q   <= civ_period.day;
					week_num_q  <= civ_period.week;
					month_num_q <= civ_period.month;
					year_num_q  <= civ_period.year;
				end
			end
		end
	end

	assign totals.valid          = out_valid_q;
	assign totals.lifetime_total = lifetime_q;
	assign totals.day_total      = day_q;
	assign totals.week_total     = week_q;
	assign totals.month_total    = month_q;
	assign totals.year_total     = year_q;
	assign totals.session_count  = count_q;

endmodule

// ----- dv/period_totals_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_totals_monitor
// Watches the session and totals channels of calendar_period_energy_totals.
// Predicts the lifetime, day, week, month and year totals and the session count for
// every accepted session and compares each totals transaction field by field, in order.
// ----------------------------------------------------------------------------
module period_totals_monitor
	import cpet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cpet_in_if          session,
	cpet_out_if         totals,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	localparam logic [31:0] SecsPerDay   = 32'd86400;
	localparam logic [31:0] MondayOffset = 32'd3;
	localparam logic [31:0] WeekDays     = 32'd7;
	localparam logic [31:0] MonthsInYear = 32'd12;
	localparam int unsigned ReportLimit  = 10;

	typedef struct packed {
		logic [TotalW-1:0] lifetime;
		logic [TotalW-1:0] day;
		logic [TotalW-1:0] week;
		logic [TotalW-1:0] month;
		logic [TotalW-1:0] year;
		logic [TotalW-1:0] count;
	} totals_t;

	totals_t              pending_totals[$];
	totals_t              running;
	logic [DayNumW-1:0]   cur_day;
	logic [WeekNumW-1:0]  cur_week;
	logic [MonthNumW-1:0] cur_month;
	logic [YearNumW-1:0]  cur_year;

	// Proleptic Gregorian year and month (1..12) of a day count since 1970-01-01
	function automatic void civil_from_days(input logic [31:0] days,
		output logic [31:0] year, output logic [31:0] month);
		logic [31:0] z, era, doe, yoe, doy, mp;
		z     = days + 32'd719468;
		era   = z / 32'd146097;
		doe   = z - era * 32'd146097;
		yoe   = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
		doy   = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
		mp    = (32'd5 * doy + 32'd2) / 32'd153;
		month = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
		year  = yoe + era * 32'd400;
		if (month <= 32'd2) begin
			year = year + 32'd1;
		end
	endfunction

	// Fold one session into the running totals
	task automatic add_session(input logic [31:0] energy, input logic [31:0] secs,
		input logic ok);
		logic [31:0] days, yr, mo, wk, mn;
		running.lifetime = running.lifetime + energy;
		running.count    = running.count + 32'd1;
		if (ok) begin
			days = secs / SecsPerDay;
			civil_from_days(days, yr, mo);
			wk = (days + MondayOffset) / WeekDays;
			mn = yr * MonthsInYear + (mo - 32'd1);
			if (cur_day != days[DayNumW-1:0]) begin
				running.day = '0;
				cur_day     = days[DayNumW-1:0];
			end
			if (cur_week != wk[WeekNumW-1:0]) begin
				running.week = '0;
				cur_week     = wk[WeekNumW-1:0];
			end
			if (cur_month != mn[MonthNumW-1:0]) begin
				running.month = '0;
				cur_month     = mn[MonthNumW-1:0];
			end
			if (cur_year != yr[YearNumW-1:0]) begin
				running.year = '0;
				cur_year     = yr[YearNumW-1:0];
			end
			running.day   = running.day + energy;
			running.week  = running.week + energy;
			running.month = running.month + energy;
			running.year  = running.year + energy;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches = mismatches + 1;
			if (mismatches <= ReportLimit) begin
				$display("%0t: %s expected %0d (0x%08h), got %0d (0x%08h)",
					$realtime, name, want, want, got, got);
			end
		end
	endfunction

	// Predict on every session transaction, compare on every totals transaction
	always @(posedge clk or negedge arst_n) begin
		totals_t want;
		if (!arst_n) begin
			running       = '0;
			cur_day       = '1;
			cur_week      = '1;
			cur_month     = '1;
			cur_year      = '1;
			mismatches    = 0;
			pending_totals.delete();
			outstanding <= 0;
		end else begin
			if (session.valid && session.ready) begin
				add_session(session.session_energy, session.local_seconds, session.clock_ok);
				pending_totals.push_back(running);
			end
			if (totals.valid && totals.ready) begin
				if (pending_totals.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= ReportLimit) begin
						$display("%0t: totals transaction with no session pending", $realtime);
					end
				end else begin
					want = pending_totals.pop_front();
					check_field("lifetime_total", want.lifetime, totals.lifetime_total);
					check_field("day_total", want.day, totals.day_total);
					check_field("week_total", want.week, totals.week_total);
					check_field("month_total", want.month, totals.month_total);
					check_field("year_total", want.year, totals.year_total);
					check_field("session_count", want.count, totals.session_count);
				end
			end
			outstanding <= pending_totals.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for calendar_period_energy_totals. Drives directed
// calendar corners, then random session streams with mostly advancing local
// time, under several idle and stall mixes; the monitor does the checking.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned ItemsPerPhase = 350;
	localparam int unsigned QuietLimit    = 2000;
	localparam int unsigned DrainCycles   = 20;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;
	logic [31:0] wall_secs;

	cpet_in_if  session_ch ();
	cpet_out_if totals_ch ();

	calendar_period_energy_totals dut (
		.clk    (clk),
		.arst_n (arst_n),
		.session(session_ch),
		.totals (totals_ch)
	);

	period_totals_monitor totals_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.session    (session_ch),
		.totals     (totals_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the totals channel at random
	always @(negedge clk) begin
		totals_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// End the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((session_ch.valid && session_ch.ready) || (totals_ch.valid && totals_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one session; called and returns at a falling edge
	task automatic push_session(input logic [31:0] energy, input logic [31:0] secs,
		input logic ok);
		while ($urandom_range(99) < idle_pct) begin
			session_ch.valid <= 1'b0;
			@(negedge clk);
		end
		session_ch.valid          <= 1'b1;
		session_ch.session_energy <= energy;
		session_ch.local_seconds  <= secs;
		session_ch.clock_ok       <= ok;
		@(posedge clk);
		while (!session_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Hold the sender until every session has its totals back
	task automatic hold_for_totals();
		session_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	// Random session mostly moving forward in time, with jumps and noise
	task automatic push_random_session();
		int unsigned pick;
		logic [31:0] energy;
		pick = $urandom_range(99);
		if (pick < 70) begin
			wall_secs = wall_secs + $urandom_range(7200);
		end else if (pick < 82) begin
			wall_secs = wall_secs + $urandom_range(3 * 86400, 86400);
		end else if (pick < 90) begin
			wall_secs = wall_secs + $urandom_range(40 * 86400);
		end else if (pick < 95) begin
			wall_secs = $urandom;
		end else begin
			wall_secs = wall_secs - $urandom_range(10 * 86400);
		end
		pick = $urandom_range(99);
		if (pick < 80) begin
			energy = $urandom_range(50000);
		end else if (pick < 90) begin
			energy = $urandom;
		end else begin
			energy = 32'hFFFF0000 | $urandom_range(16'hFFFF);
		end
		push_session(energy, wall_secs, $urandom_range(99) < 88);
	endtask

	initial begin
		int unsigned sender_idle[4];
		int unsigned receiver_stall[4];
		sender_idle    = '{0, 45, 0, 24};
		receiver_stall = '{0, 0, 45, 24};
		arst_n                    = 1'b0;
		session_ch.valid          = 1'b0;
		session_ch.session_energy = '0;
		session_ch.local_seconds  = '0;
		session_ch.clock_ok       = 1'b0;
		totals_ch.ready           = 1'b0;
		idle_pct                  = 0;
		stall_pct                 = 0;
		quiet_cycles              = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Invalid clock before any valid session: periods stay at reset
		push_session(32'd100, 32'hFFFFFFFF, 1'b0);
		// First valid session clears every period, epoch start on a Thursday
		push_session(32'd0, 32'd0, 1'b1);
		push_session(32'hFFFFFFFF, 32'd100, 1'b1);
		push_session(32'hFFFFFFFF, 32'd3600, 1'b1);
		// Sunday night, then Monday: new day and new week
		push_session(32'd7, 32'd345599, 1'b1);
		push_session(32'd11, 32'd345600, 1'b1);
		// Month boundary
		push_session(32'd13, 32'd2678399, 1'b1);
		push_session(32'd17, 32'd2678400, 1'b1);
		// Invalid clock between valid sessions is ignored by the periods
		push_session(32'd19, 32'd951782400, 1'b0);
		// Year boundary
		push_session(32'd23, 32'd31535999, 1'b1);
		push_session(32'd29, 32'd31536000, 1'b1);
		// Leap day of a 400-year leap year
		push_session(32'd31, 32'd951696000, 1'b1);
		push_session(32'd37, 32'd951782400, 1'b1);
		push_session(32'd41, 32'd951868800, 1'b1);
		// Century year without a leap day
		push_session(32'd43, 32'd4107456000, 1'b1);
		push_session(32'd47, 32'd4107542400, 1'b1);
		// Back in time to an earlier day
		push_session(32'd53, 32'd951782400, 1'b1);
		// Last representable second, totals wrapping
		push_session(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		push_session(32'hFFFFFFFF, 32'hFFFFFF00, 1'b1);
		push_session(32'h80000000, 32'hFFFFFFFF, 1'b1);
		push_session(32'h80000000, 32'hFFFFFFFF, 1'b0);
		hold_for_totals();

		// Random sessions under each idle and stall mix
		wall_secs = $urandom;
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = sender_idle[phase];
			stall_pct = receiver_stall[phase];
			for (int n = 0; n < ItemsPerPhase; n++) begin
				push_random_session();
			end
			if (phase == 1) begin
				hold_for_totals();
			end
		end

		// Drain and give the verdict
		session_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/cpet_pkg.sv
hw/rtl/cpet_in_if.sv
hw/rtl/cpet_out_if.sv
hw/rtl/cpet_civil.sv
hw/rtl/calendar_period_energy_totals.sv
dv/period_totals_monitor.sv
dv/tb.sv
